// ===== hdl/qwsm_pkg.sv =====
// ============================================================================
// qwsm_pkg - shared constants for the quadrature wheel speed meter
// Count width, field widths, speed arithmetic widths and register indexes.
// ============================================================================
`default_nettype none

package qwsm_pkg;

    // Width of the wrapping tick counters and their snapshots
    localparam int COUNT_WIDTH = 32;

    // Result field width (deltas and speeds)
    localparam int FIELD_WIDTH = 32;

    // Configuration registers
    localparam int INTERVAL_WIDTH = 16;
    localparam int SCALE_WIDTH    = 24;
    localparam int CFG_DATA_WIDTH = 24;
    localparam int CFG_IDX_WIDTH  = 2;

    localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = 16'd100;
    localparam logic [SCALE_WIDTH-1:0]    SCALE_RESET    = 24'd14298;

    // Speed arithmetic: magnitude times Q16 scale, then drop 8 fraction bits
    localparam int FRAC_DROP    = 8;
    localparam int PROD_WIDTH   = COUNT_WIDTH + SCALE_WIDTH;
    localparam int ROUND_WIDTH  = PROD_WIDTH + 1 - FRAC_DROP;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_INTERVAL_MS = 2'd0,
        REG_SPEED_SCALE = 2'd1
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hdl/qwsm_sample_if.sv =====
// ============================================================================
// qwsm_sample_if - pin sample channel
// One beat carries one clock's sample of both encoders' pins and the ms strobe.
// ============================================================================
`default_nettype none

interface qwsm_sample_if;

    logic valid;
    logic ready;
    logic wheel1_a;
    logic wheel1_b;
    logic wheel2_a;
    logic wheel2_b;
    logic ms_tick;

    modport source (
        output valid, wheel1_a, wheel1_b, wheel2_a, wheel2_b, ms_tick,
        input  ready
    );

    modport sink (
        input  valid, wheel1_a, wheel1_b, wheel2_a, wheel2_b, ms_tick,
        output ready
    );

endinterface

`default_nettype wire

// ===== hdl/qwsm_result_if.sv =====
// ============================================================================
// qwsm_result_if - measurement result channel
// One beat carries both wheels' interval deltas, speeds and the error flag.
// ============================================================================
`default_nettype none

interface qwsm_result_if;

    logic                                          valid;
    logic                                          ready;
    logic signed [qwsm_pkg::FIELD_WIDTH-1:0]       wheel1_delta;
    logic signed [qwsm_pkg::FIELD_WIDTH-1:0]       wheel2_delta;
    logic signed [qwsm_pkg::FIELD_WIDTH-1:0]       wheel1_speed;
    logic signed [qwsm_pkg::FIELD_WIDTH-1:0]       wheel2_speed;
    logic                                          decode_error;

    modport source (
        output valid, wheel1_delta, wheel2_delta, wheel1_speed, wheel2_speed,
               decode_error,
        input  ready
    );

    modport sink (
        input  valid, wheel1_delta, wheel2_delta, wheel1_speed, wheel2_speed,
               decode_error,
        output ready
    );

endinterface

`default_nettype wire

// ===== hdl/quadrature_wheel_speed_meter_top.sv =====
// ============================================================================
// quadrature_wheel_speed_meter_top - two-wheel x4 quadrature decoder and meter
// Decodes two encoders into wrapping tick counters and reports interval
// deltas and scaled speeds every interval_ms millisecond strobes.
// ============================================================================
//
// Usage:
//   samples : one beat per clock sample of both encoders' A/B pins and the
//             millisecond strobe. Counters and last pins update on the beat.
//   results : one beat per completed interval: both deltas, both speeds
//             (cm/s, 8 fraction bits, rounded and saturated) and the sticky
//             decode error flag, which includes the closing sample.
//   config  : cfg_wr_en/cfg_index/cfg_data; index 0 interval_ms, index 1
//             speed_scale, other indexes ignored. Write only while idle.
// Throughput: one sample per cycle while samples.ready is high. The closing
//   sample's result passes the delta stage, multiplier stage (magnitude
//   times scale) and the rounding/saturation output register in turn.
// Reset: counters, snapshots, ms count and error flag clear, last pins go to
//   all ones, registers return to 100 and 14298, the result pipe empties.
// Stall: the three result stages hold in turn; samples keep flowing until
//   all three hold a result, then samples.ready drops.
//
`default_nettype none

module quadrature_wheel_speed_meter_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    qwsm_sample_if.sink                                 samples,
    qwsm_result_if.source                               results,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [qwsm_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  wire logic [qwsm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    localparam int CW = qwsm_pkg::COUNT_WIDTH;
    localparam int FW = qwsm_pkg::FIELD_WIDTH;
    localparam int PW = qwsm_pkg::PROD_WIDTH;
    localparam int RW = qwsm_pkg::ROUND_WIDTH;
    localparam int IW = qwsm_pkg::INTERVAL_WIDTH;
    localparam int SW = qwsm_pkg::SCALE_WIDTH;

    localparam logic [IW-1:0] MS_MAX = {IW{1'b1}};
    localparam logic [RW-1:0] POS_LIMIT = RW'({1'b0, {(FW-1){1'b1}}});
    localparam logic [RW-1:0] NEG_LIMIT = RW'({1'b1, {(FW-1){1'b0}}});
    localparam logic [PW:0]   ROUND_HALF = (PW+1)'(1) << (qwsm_pkg::FRAC_DROP - 1);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [CW-1:0] count_step(
        input logic [CW-1:0] count,
        input logic a, input logic b, input logic pa, input logic pb
    );
        logic ea;
        logic eb;
        logic up;
        ea = a ^ pa;
        eb = b ^ pb;
        up = ea ? (a ^ b) : ~(a ^ b);
        if (ea ^ eb)
            count_step = up ? count + CW'(1) : count - CW'(1);
        else
            count_step = count;
    endfunction

    function automatic logic [FW-1:0] speed_sat(input logic neg, input logic [PW-1:0] prod);
        logic [PW:0]   sum;
        logic [RW-1:0] r;
        sum = {1'b0, prod} + ROUND_HALF;
        r   = sum[PW:qwsm_pkg::FRAC_DROP];
        if (neg)
            speed_sat = (r > NEG_LIMIT) ? NEG_LIMIT[FW-1:0] : (FW'(0) - r[FW-1:0]);
        else
            speed_sat = (r > POS_LIMIT) ? POS_LIMIT[FW-1:0] : r[FW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [IW-1:0] interval_reg;
    logic [SW-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= qwsm_pkg::INTERVAL_RESET;
            scale_reg    <= qwsm_pkg::SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                qwsm_pkg::REG_INTERVAL_MS: interval_reg <= cfg_data[IW-1:0];
                qwsm_pkg::REG_SPEED_SCALE: scale_reg    <= cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipe handshake: each stage moves when the one after it is free
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s3_free;
    logic s2_move;
    logic s2_free;
    logic s1_move;
    logic s1_free;
    logic accept;

    assign s3_free = !s3_valid_reg || results.ready;
    assign s2_move = s2_valid_reg && s3_free;
    assign s2_free = !s2_valid_reg || s3_free;
    assign s1_move = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s2_free;
    assign samples.ready = s1_free;
    assign accept = samples.valid && s1_free;

    // ------------------------------------------------------------------
    // Decode and interval logic for the accepted sample
    // ------------------------------------------------------------------
    logic [3:0]    last_pins_reg;
    logic [CW-1:0] count1_reg;
    logic [CW-1:0] count2_reg;
    logic [CW-1:0] snap1_reg;
    logic [CW-1:0] snap2_reg;
    logic [IW-1:0] ms_elapsed_reg;
    logic          error_seen_reg;

    logic [CW-1:0] count1_next;
    logic [CW-1:0] count2_next;
    logic [IW-1:0] ms_inc;
    logic          error_next;
    logic          fire;

    always_comb
    begin
        count1_next = count_step(count1_reg, samples.wheel1_a, samples.wheel1_b,
                                 last_pins_reg[0], last_pins_reg[1]);
        count2_next = count_step(count2_reg, samples.wheel2_a, samples.wheel2_b,
                                 last_pins_reg[2], last_pins_reg[3]);
        error_next  = error_seen_reg
                    | ((samples.wheel1_a ^ last_pins_reg[0]) & (samples.wheel1_b ^ last_pins_reg[1]))
                    | ((samples.wheel2_a ^ last_pins_reg[2]) & (samples.wheel2_b ^ last_pins_reg[3]));
        ms_inc      = (ms_elapsed_reg != MS_MAX) ? ms_elapsed_reg + IW'(1) : ms_elapsed_reg;
        fire        = samples.ms_tick && (ms_inc >= interval_reg);
    end

    // Advance decoder state on each sample beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pins_reg  <= 4'hF;
            count1_reg     <= '0;
            count2_reg     <= '0;
            snap1_reg      <= '0;
            snap2_reg      <= '0;
            ms_elapsed_reg <= '0;
            error_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            last_pins_reg  <= {samples.wheel2_b, samples.wheel2_a,
                               samples.wheel1_b, samples.wheel1_a};
            count1_reg     <= count1_next;
            count2_reg     <= count2_next;
            error_seen_reg <= error_next;
            if (samples.ms_tick)
                ms_elapsed_reg <= fire ? '0 : ms_inc;
            if (fire)
            begin
                snap1_reg <= count1_next;
                snap2_reg <= count2_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: interval deltas
    // ------------------------------------------------------------------
    logic signed [CW-1:0] s1_d1_reg;
    logic signed [CW-1:0] s1_d2_reg;
    logic                 s1_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= accept && fire;
    end

    always_ff @(posedge clk)
    begin
        if (accept && fire)
        begin
            s1_d1_reg  <= count1_next - snap1_reg;
            s1_d2_reg  <= count2_next - snap2_reg;
            s1_err_reg <= error_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude times scale
    // ------------------------------------------------------------------
    logic [CW-1:0] mag1;
    logic [CW-1:0] mag2;

    assign mag1 = s1_d1_reg[CW-1] ? (CW'(0) - s1_d1_reg) : s1_d1_reg;
    assign mag2 = s1_d2_reg[CW-1] ? (CW'(0) - s1_d2_reg) : s1_d2_reg;

    logic [PW-1:0] s2_prod1_reg;
    logic [PW-1:0] s2_prod2_reg;
    logic          s2_neg1_reg;
    logic          s2_neg2_reg;
    logic [FW-1:0] s2_d1_reg;
    logic [FW-1:0] s2_d2_reg;
    logic          s2_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_prod1_reg <= PW'(mag1) * PW'(scale_reg);
            s2_prod2_reg <= PW'(mag2) * PW'(scale_reg);
            s2_neg1_reg  <= s1_d1_reg[CW-1];
            s2_neg2_reg  <= s1_d2_reg[CW-1];
            s2_d1_reg    <= FW'(s1_d1_reg);
            s2_d2_reg    <= FW'(s1_d2_reg);
            s2_err_reg   <= s1_err_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round, saturate and hold the result beat
    // ------------------------------------------------------------------
    logic [FW-1:0] s3_d1_reg;
    logic [FW-1:0] s3_d2_reg;
    logic [FW-1:0] s3_v1_reg;
    logic [FW-1:0] s3_v2_reg;
    logic          s3_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_free)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_d1_reg  <= s2_d1_reg;
            s3_d2_reg  <= s2_d2_reg;
            s3_v1_reg  <= speed_sat(s2_neg1_reg, s2_prod1_reg);
            s3_v2_reg  <= speed_sat(s2_neg2_reg, s2_prod2_reg);
            s3_err_reg <= s2_err_reg;
        end
    end

    assign results.valid        = s3_valid_reg;
    assign results.wheel1_delta = s3_d1_reg;
    assign results.wheel2_delta = s3_d2_reg;
    assign results.wheel1_speed = s3_v1_reg;
    assign results.wheel2_speed = s3_v2_reg;
    assign results.decode_error = s3_err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A result enters the pipe only on a millisecond strobe
    a_fire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fire) |-> samples.ms_tick)
        else $error("result started without a ms strobe");

    // Samples stall only when every result stage is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg))
        else $error("sample channel stalled with room in the pipe");

    // Error flag is sticky
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_seen_reg |=> error_seen_reg)
        else $error("decode error flag cleared");

    // Wheel one speed is never negative while its delta is non-negative
    a_speed_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.wheel1_delta[FW-1]) |-> !results.wheel1_speed[FW-1])
        else $error("wheel one speed sign disagrees with delta");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ============================================================================
// tb - self-checking bench for the quadrature wheel speed meter
// Streams pin samples of two encoders with millisecond strobes into the
// block, predicts each interval result (deltas, rounded and saturated
// speeds, sticky decode error) and compares every result beat with the
// oldest prediction. Both channels idle and stall in random bursts.
// ============================================================================

module tb;

    import qwsm_pkg::*;

    localparam int LATENCY    = 3;
    localparam int HOLD_OFF   = LATENCY + 5;
    localparam int QUIET_MAX  = 4000;

    localparam longint SPEED_MAX = 64'sd2147483647;
    localparam longint SPEED_MIN = -64'sd2147483648;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic signed [FIELD_WIDTH-1:0] wheel1_delta;
        logic signed [FIELD_WIDTH-1:0] wheel2_delta;
        logic signed [FIELD_WIDTH-1:0] wheel1_speed;
        logic signed [FIELD_WIDTH-1:0] wheel2_speed;
        logic                          decode_error;
    } meas_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    qwsm_sample_if pin_ch ();
    qwsm_result_if meas_ch ();

    quadrature_wheel_speed_meter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (pin_ch),
        .results   (meas_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state and its copy of the registers
    logic [3:0]                prev_pins;
    logic [COUNT_WIDTH-1:0]    tick_count [2];
    logic [COUNT_WIDTH-1:0]    tick_mark [2];
    logic [INTERVAL_WIDTH-1:0] strobe_count;
    logic                      sticky_err;
    logic [INTERVAL_WIDTH-1:0] cfg_interval;
    logic [SCALE_WIDTH-1:0]    cfg_scale;

    meas_t pending_meas [$];
    meas_t oldest_meas;

    // Stimulus bookkeeping
    logic [3:0]  drive_pins;
    int          wheel_drift [2];
    bit          sender_idle;
    bit          calm;
    int unsigned samples_sent;
    int unsigned meas_checked;
    int unsigned reg_writes;
    int unsigned fail_count;
    int unsigned quiet_cycles;
    int unsigned ready_hold;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [COUNT_WIDTH-1:0] quad_step(
        input  logic [COUNT_WIDTH-1:0] count,
        input  logic a, b, pa, pb,
        output logic both
    );
        both = 1'b0;
        if (a != pa && b != pb)
        begin
            both = 1'b1;
            return count;
        end
        if (a != pa)
            return (a != b) ? count + 1'b1 : count - 1'b1;
        if (b != pb)
            return (a == b) ? count + 1'b1 : count - 1'b1;
        return count;
    endfunction

    // Delta times Q16 scale, drop 8 fraction bits, round half away, clamp
    function automatic logic signed [FIELD_WIDTH-1:0] speed_of_delta(
        input logic signed [COUNT_WIDTH-1:0] delta,
        input logic [SCALE_WIDTH-1:0]        scale
    );
        longint prod;
        longint r;
        prod = longint'(delta) * longint'(scale);
        if (prod >= 0)
            r = (prod + (64'sd1 <<< (FRAC_DROP - 1))) >>> FRAC_DROP;
        else
            r = -((-prod + (64'sd1 <<< (FRAC_DROP - 1))) >>> FRAC_DROP);
        if (r > SPEED_MAX)
            r = SPEED_MAX;
        if (r < SPEED_MIN)
            r = SPEED_MIN;
        return r[FIELD_WIDTH-1:0];
    endfunction

    task automatic meter_reset();
        prev_pins    = 4'hF;
        tick_count   = '{default: '0};
        tick_mark    = '{default: '0};
        strobe_count = '0;
        sticky_err   = 1'b0;
        cfg_interval = INTERVAL_RESET;
        cfg_scale    = SCALE_RESET;
    endtask

    // Pins: bit0 wheel1 A, bit1 wheel1 B, bit2 wheel2 A, bit3 wheel2 B
    task automatic meter_predict(input logic [3:0] pins, input logic strobe);
        logic both;
        meas_t m;
        logic signed [COUNT_WIDTH-1:0] delta [2];
        for (int w = 0; w < 2; w++)
        begin
            tick_count[w] = quad_step(tick_count[w], pins[2*w], pins[2*w+1],
                                      prev_pins[2*w], prev_pins[2*w+1], both);
            if (both)
                sticky_err = 1'b1;
        end
        prev_pins = pins;
        if (!strobe)
            return;
        if (strobe_count != '1)
            strobe_count++;
        if (strobe_count < cfg_interval)
            return;
        strobe_count = '0;
        for (int w = 0; w < 2; w++)
        begin
            delta[w]     = tick_count[w] - tick_mark[w];
            tick_mark[w] = tick_count[w];
        end
        m.wheel1_delta = FIELD_WIDTH'(delta[0]);
        m.wheel2_delta = FIELD_WIDTH'(delta[1]);
        m.wheel1_speed = speed_of_delta(delta[0], cfg_scale);
        m.wheel2_speed = speed_of_delta(delta[1], cfg_scale);
        m.decode_error = sticky_err;
        pending_meas.push_back(m);
    endtask

    // ------------------------------------------------------------------
    // Sample channel driving
    // ------------------------------------------------------------------

    task automatic send_sample(input logic a1, b1, a2, b2, tick);
        int gap;
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            pin_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pin_ch.valid    <= 1'b1;
        pin_ch.wheel1_a <= a1;
        pin_ch.wheel1_b <= b1;
        pin_ch.wheel2_a <= a2;
        pin_ch.wheel2_b <= b2;
        pin_ch.ms_tick  <= tick;
        @(posedge clk);
        while (!pin_ch.ready)
            @(posedge clk);
        drive_pins = {b2, a2, b1, a1};
        meter_predict(drive_pins, tick);
        samples_sent++;
    endtask

    // Move one encoder a quarter step along its Gray cycle 00,10,11,01 (A,B).
    // A dir of 2 flips both pins at once.
    function automatic logic [1:0] next_pair(input logic [1:0] ba, input int dir);
        int ph;
        if (dir == 2)
            return ~ba;
        case (ba)
            2'b00:   ph = 0;
            2'b01:   ph = 1;
            2'b11:   ph = 2;
            default: ph = 3;
        endcase
        ph = (ph + dir + 4) % 4;
        return {ph == 2 || ph == 3, ph == 1 || ph == 2};
    endfunction

    task automatic step_wheels(input int dir1, input int dir2, input logic tick);
        logic [1:0] w1;
        logic [1:0] w2;
        w1 = next_pair(drive_pins[1:0], dir1);
        w2 = next_pair(drive_pins[3:2], dir2);
        send_sample(w1[0], w1[1], w2[0], w2[1], tick);
    endtask

    // Walk both encoders forward until both pins sit high
    task automatic park_wheels();
        while (drive_pins != 4'hF)
            step_wheels(drive_pins[1:0] != 2'b11, drive_pins[3:2] != 2'b11, 1'b0);
    endtask

    task automatic random_item(input int tick_pct, input int noise_pct, input int err_pct);
        logic [3:0] p;
        int d [2];
        int r;
        if ($urandom_range(0, 99) < noise_pct)
        begin
            p = 4'($urandom);
            send_sample(p[0], p[1], p[2], p[3], $urandom_range(0, 99) < tick_pct);
            return;
        end
        for (int w = 0; w < 2; w++)
        begin
            r = $urandom_range(0, 99);
            if (r < err_pct)
                d[w] = 2;
            else if (r < 60)
                d[w] = wheel_drift[w];
            else if (r < 85)
                d[w] = 0;
            else
                d[w] = -wheel_drift[w];
        end
        step_wheels(d[0], d[1], $urandom_range(0, 99) < tick_pct);
    endtask

    task automatic run_phase(input int n, input int tick_pct, input int noise_pct,
                             input int err_pct);
        wheel_drift[0] = $urandom_range(0, 1) ? 1 : -1;
        wheel_drift[1] = $urandom_range(0, 1) ? 1 : -1;
        repeat (n) random_item(tick_pct, noise_pct, err_pct);
    endtask

    // Hold samples back until every predicted result has been taken
    task automatic wait_results();
        pin_ch.valid <= 1'b0;
        while (pending_meas.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        wait_results();
        repeat (HOLD_OFF) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_INTERVAL_MS)
            cfg_interval = value[INTERVAL_WIDTH-1:0];
        else if (idx == REG_SPEED_SCALE)
            cfg_scale = value[SCALE_WIDTH-1:0];
        reg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register values straight out of reset, clean quadrature only
    task automatic test_reset_settings();
        run_phase(240, 88, 0, 0);
        park_wheels();
    endtask

    // Every transition both ways, simultaneous changes, scale extremes, ties
    task automatic test_pin_decode();
        write_reg(REG_INTERVAL_MS, 24'd1);
        send_sample(1, 1, 1, 1, 1);
        send_sample(0, 1, 1, 0, 0);
        send_sample(0, 0, 0, 0, 0);
        send_sample(1, 0, 0, 1, 0);
        send_sample(1, 1, 1, 1, 1);
        send_sample(0, 0, 1, 1, 1);
        send_sample(0, 0, 0, 0, 0);
        send_sample(0, 0, 0, 0, 1);
        write_reg(REG_SPEED_SCALE, 24'd0);
        send_sample(1, 0, 0, 1, 1);
        write_reg(REG_SPEED_SCALE, 24'hFFFFFF);
        send_sample(1, 1, 1, 1, 1);
        write_reg(REG_SPEED_SCALE, 24'd128);
        send_sample(0, 1, 1, 0, 1);
        send_sample(0, 0, 0, 0, 0);
        send_sample(1, 0, 0, 1, 0);
        send_sample(1, 1, 1, 1, 1);
    endtask

    // Longest interval, truncation of a wide write, then shrink and zero
    task automatic test_interval_limits();
        write_reg(REG_SPEED_SCALE, SCALE_RESET);
        write_reg(REG_INTERVAL_MS, 24'hFFFFFF);
        run_phase(150, 100, 5, 2);
        write_reg(REG_INTERVAL_MS, 24'd3);
        run_phase(20, 60, 5, 2);
        write_reg(REG_INTERVAL_MS, 24'd0);
        run_phase(20, 50, 5, 2);
    endtask

    // Writes to undecoded indexes must leave both registers alone
    task automatic test_spare_index();
        write_reg(REG_INTERVAL_MS, 24'd2);
        write_reg(REG_SPARE_2, CFG_DATA_WIDTH'($urandom));
        write_reg(REG_SPARE_3, CFG_DATA_WIDTH'($urandom));
        run_phase(40, 70, 5, 2);
    endtask

    // Steady one-way travel, wheels opposite, at the largest scale
    task automatic test_long_travel();
        sender_idle = 1'b0;
        write_reg(REG_INTERVAL_MS, 24'd1);
        write_reg(REG_SPEED_SCALE, 24'hFFFFFF);
        step_wheels(0, 0, 1'b1);
        repeat (32) step_wheels(1, -1, 1'b0);
        step_wheels(1, -1, 1'b1);
        sender_idle = 1'b1;
    endtask

    // A result every sample, so receiver stalls fill the result pipe
    task automatic test_back_pressure();
        sender_idle = 1'b0;
        write_reg(REG_SPEED_SCALE, CFG_DATA_WIDTH'($urandom));
        write_reg(REG_INTERVAL_MS, 24'd1);
        run_phase(150, 100, 10, 2);
        sender_idle = 1'b1;
    endtask

    // Phases with fresh settings; the last one runs without any idling
    task automatic test_random_walk();
        logic [CFG_DATA_WIDTH-1:0] iv;
        logic [CFG_DATA_WIDTH-1:0] sc;
        for (int ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(0, 3))
                0:       iv = 24'd1;
                1:       iv = 24'd2;
                2:       iv = CFG_DATA_WIDTH'($urandom_range(3, 8));
                default: iv = CFG_DATA_WIDTH'($urandom_range(9, 30));
            endcase
            case ($urandom_range(0, 3))
                0:       sc = 24'd0;
                1:       sc = 24'hFFFFFF;
                2:       sc = CFG_DATA_WIDTH'($urandom);
                default: sc = CFG_DATA_WIDTH'($urandom_range(1, 300));
            endcase
            if (ph == 5)
            begin
                calm        = 1'b1;
                sender_idle = 1'b0;
            end
            write_reg(REG_INTERVAL_MS, iv);
            write_reg(REG_SPEED_SCALE, sc);
            run_phase(130, $urandom_range(20, 100), 10, 3);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stall bursts and checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            ready_hold    <= $urandom_range(0, 7);
            meas_ch.ready <= calm || $urandom_range(0, 2) != 0;
        end
    end

    task automatic check_field(input string name, input logic [FIELD_WIDTH-1:0] want,
                               input logic [FIELD_WIDTH-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && meas_ch.valid && meas_ch.ready)
        begin
            if (pending_meas.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                oldest_meas = pending_meas.pop_front();
                check_field("wheel1_delta", oldest_meas.wheel1_delta, meas_ch.wheel1_delta);
                check_field("wheel2_delta", oldest_meas.wheel2_delta, meas_ch.wheel2_delta);
                check_field("wheel1_speed", oldest_meas.wheel1_speed, meas_ch.wheel1_speed);
                check_field("wheel2_speed", oldest_meas.wheel2_speed, meas_ch.wheel2_speed);
                check_field("decode_error", FIELD_WIDTH'(oldest_meas.decode_error),
                            FIELD_WIDTH'(meas_ch.decode_error));
                meas_checked++;
            end
        end
    end

    // Give up when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (pin_ch.valid && pin_ch.ready) || (meas_ch.valid && meas_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_MAX)
        begin
            $display("tb: stalled, %0d results outstanding", pending_meas.size());
            $display("tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_INTERVAL_MS;
        cfg_data        = '0;
        pin_ch.valid    = 1'b0;
        pin_ch.wheel1_a = 1'b1;
        pin_ch.wheel1_b = 1'b1;
        pin_ch.wheel2_a = 1'b1;
        pin_ch.wheel2_b = 1'b1;
        pin_ch.ms_tick  = 1'b0;
        meas_ch.ready   = 1'b0;
        ready_hold      = 0;
        quiet_cycles    = 0;
        drive_pins      = 4'hF;
        sender_idle     = 1'b1;
        calm            = 1'b0;
        samples_sent    = 0;
        meas_checked    = 0;
        reg_writes      = 0;
        fail_count      = 0;
        meter_reset();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_pin_decode();
        test_interval_limits();
        test_spare_index();
        test_long_travel();
        test_back_pressure();
        test_random_walk();

        // Drain, then let the pipe settle
        wait_results();
        repeat (HOLD_OFF) @(posedge clk);

        $display("tb: %0d pin samples sent, %0d interval results checked, %0d register writes",
                 samples_sent, meas_checked, reg_writes);
        $display("tb: covered x4 decode both ways, double edges, interval and scale extremes");
        if (fail_count == 0 && pending_meas.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/qwsm_pkg.sv
hdl/qwsm_sample_if.sv
hdl/qwsm_result_if.sv
hdl/quadrature_wheel_speed_meter_top.sv
tb/sv/tb.sv
